### hdl/svh_pkg.sv
// shared types and constants of the smoothed value histogram
package svh_pkg;

    // default sizes of the count store
    localparam int NUM_BINS_DEF    = 256;
    localparam int COUNT_WIDTH_DEF = 24;

    // field widths
    localparam int OP_W       = 2;
    localparam int SAMPLE_W   = 32;
    localparam int INDEX_W    = 8;
    localparam int VALUE_W    = 32;
    localparam int FRAC_W     = 8;
    localparam int BIN_SIZE_W = 31;
    localparam int START_W    = 32;
    localparam int BINS_W     = 9;
    localparam int SMOOTH_W   = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // operation codes
    localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_SIZE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_VALUE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BINS_IN_USE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH_WIDTH = 2'd3;

    // register reset values
    localparam logic [BIN_SIZE_W-1:0] BIN_SIZE_RST     = 31'd65536;
    localparam logic [START_W-1:0]    START_VALUE_RST  = 32'd0;
    localparam logic [BINS_W-1:0]     BINS_IN_USE_RST  = 9'd256;
    localparam logic [SMOOTH_W-1:0]   SMOOTH_WIDTH_RST = 8'd0;

    typedef struct packed {
        logic [OP_W-1:0]            operation;
        logic signed [SAMPLE_W-1:0] sample;
        logic [INDEX_W-1:0]         read_index;
    } t_in_item;

    typedef struct packed {
        logic [INDEX_W-1:0] bin_index;
        logic [VALUE_W-1:0] smoothed_value;
    } t_out_item;

endpackage

### hdl/svh_div.sv
// restoring divider, one quotient bit per cycle
module svh_div #(
    parameter int NW = 48,
    parameter int DW = 32,
    parameter int QB = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [NW-1:0]              i_num,
    input  logic [DW-1:0]              i_den,
    input  logic [$clog2(QB+1)-1:0]    i_steps,
    output logic                       o_done,
    output logic [QB-1:0]              o_quo
);
    localparam int SW  = DW + QB;
    localparam int SBW = $clog2(QB + 1);

    logic [SW-1:0]  r_rem;
    logic [SW-1:0]  r_dsh;
    logic [QB-1:0]  r_quo;
    logic [SBW-1:0] r_cnt;
    logic           r_done;
    logic           fits;

    // numerator must stay below den << i_steps, i_steps at least one
    assign fits = (r_rem >= r_dsh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= i_steps;
            r_done <= 1'b0;
        end else if (r_cnt != '0) begin
            r_cnt  <= r_cnt - 1'b1;
            r_done <= (r_cnt == SBW'(1));
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= SW'(i_num);
            r_dsh <= SW'(i_den) << (i_steps - 1'b1);
            r_quo <= '0;
        end else if (r_cnt != '0) begin
            if (fits) begin
                r_rem <= r_rem - r_dsh;
            end
            r_quo <= {r_quo[QB-2:0], fits};
            r_dsh <= r_dsh >> 1;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

### hdl/smoothed_value_histogram_top.sv
// smoothed value histogram: count store, bin divider and window averaging
//
//  channel   direction  handshake                     payload
//  item      in         start & !busy                 i_item   (svh_pkg::t_in_item)
//  result    out        o_valid, one cycle, no stall  o_result (svh_pkg::t_out_item)
//  config    in         i_cfg_we                      i_cfg_idx, i_cfg_data
//
// one item at a time; busy stays high until the item is done
// add: the bin number comes from the bit-serial bin divider
// read: 2w+1 memory reads (w = window half-width), then the mean divider
// clear: one store entry written per cycle; reset starts the same sweep
// results cannot be held off: each one shows for exactly one cycle
module smoothed_value_histogram_top #(
    parameter int NUM_BINS    = svh_pkg::NUM_BINS_DEF,
    parameter int COUNT_WIDTH = svh_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    input  svh_pkg::t_in_item                   i_item,
    output logic                                busy,
    output logic                                o_valid,
    output svh_pkg::t_out_item                  o_result,
    input  logic                                i_cfg_we,
    input  logic [svh_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [svh_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    // address of one bin
    localparam int AW   = $clog2(NUM_BINS);
    // width that holds the active bin count, NUM_BINS included
    localparam int NBW  = $clog2(NUM_BINS + 1);
    // window arithmetic width, covers both bin index and bin count
    localparam int XW   = (NBW > svh_pkg::INDEX_W) ? NBW : svh_pkg::INDEX_W;
    // window holds at most 255 bins
    localparam int SUMW = COUNT_WIDTH + svh_pkg::SMOOTH_W;
    // divider numerator: (2*mag + bin_size) or (sum << 8)
    localparam int ANW  = svh_pkg::SAMPLE_W + 2;
    localparam int MNW  = SUMW + svh_pkg::FRAC_W;
    localparam int DNW  = (MNW > ANW) ? MNW : ANW;
    // divisor: 2*bin_size or window length
    localparam int DDW  = svh_pkg::BIN_SIZE_W + 1;
    localparam int QB   = svh_pkg::VALUE_W;
    localparam int SBW  = $clog2(QB + 1);
    localparam int CMPW = 2 * svh_pkg::VALUE_W;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_CLR   = 11'b000_0000_0010,
        S_ADIFF = 11'b000_0000_0100,
        S_ANUM  = 11'b000_0000_1000,
        S_ACHK  = 11'b000_0001_0000,
        S_ADIV  = 11'b000_0010_0000,
        S_AINC  = 11'b000_0100_0000,
        S_RSET  = 11'b000_1000_0000,
        S_SUM   = 11'b001_0000_0000,
        S_MCHK  = 11'b010_0000_0000,
        S_MDIV  = 11'b100_0000_0000
    } t_state;

    t_state r_state;

    // configuration
    logic [svh_pkg::BIN_SIZE_W-1:0] r_bin_size;
    logic [svh_pkg::START_W-1:0]    r_start;
    logic [svh_pkg::BINS_W-1:0]     r_bins;
    logic [svh_pkg::SMOOTH_W-1:0]   r_smooth;

    // item in flight
    logic [svh_pkg::SAMPLE_W-1:0]   r_samp;
    logic [svh_pkg::INDEX_W-1:0]    r_k;
    logic                           r_neg;
    logic [svh_pkg::SAMPLE_W:0]     r_mag;
    logic [ANW-1:0]                 r_num;
    logic [AW-1:0]                  r_bin;
    logic [AW-1:0]                  r_addr;
    logic [svh_pkg::SMOOTH_W-1:0]   r_left;
    logic [svh_pkg::SMOOTH_W-1:0]   r_cnt;
    logic                           r_rd_vld;
    logic [SUMW-1:0]                r_sum;

    // result register
    logic                           r_valid;
    svh_pkg::t_out_item             r_result;

    // count store
    logic [COUNT_WIDTH-1:0]         mem [NUM_BINS];
    logic [COUNT_WIDTH-1:0]         r_rd_data;
    logic                           mem_we;
    logic [AW-1:0]                  mem_wa;
    logic [COUNT_WIDTH-1:0]         mem_wd;
    logic [AW-1:0]                  mem_ra;

    // divider hookup
    logic                           div_start;
    logic [DNW-1:0]                 div_num;
    logic [DDW-1:0]                 div_den;
    logic [SBW-1:0]                 div_steps;
    logic                           div_done;
    logic [QB-1:0]                  div_quo;

    // datapath helpers
    logic [NBW-1:0]                 n_act;
    logic [svh_pkg::SAMPLE_W:0]     diff;
    logic                           drop_a;
    logic                           ovf_a;
    logic [AW-1:0]                  q_bin;
    logic                           keep_a;
    logic [XW-1:0]                  kx;
    logic [XW-1:0]                  nx;
    logic [XW-1:0]                  hx;
    logic [XW-1:0]                  room;
    logic [XW-1:0]                  w1;
    logic [XW-1:0]                  wx;
    logic                           sat_m;
    logic                           accept;

    assign accept = start && (r_state == S_IDLE);
    assign busy   = (r_state != S_IDLE);

    // bins in use, clamped to the store size
    assign n_act = (32'(r_bins) > 32'(NUM_BINS)) ? NBW'(NUM_BINS) : NBW'(r_bins);

    // add path: signed distance from the center of bin zero
    assign diff   = {r_samp[svh_pkg::SAMPLE_W-1], r_samp} - {r_start[svh_pkg::START_W-1], r_start};
    assign drop_a = (r_samp == '0) || (r_bin_size == '0) || (n_act == '0);

    // quotient would not fit the bin address, so the bin is out of range anyway
    assign ovf_a  = CMPW'(r_num) >= (CMPW'(r_bin_size) << (AW + 1));

    // negative distances only land in bin zero (rounded to it)
    assign q_bin  = div_quo[AW-1:0];
    assign keep_a = !(r_neg && (q_bin != '0)) && (NBW'(q_bin) < n_act);

    // read path: window half-width min(h, k, n-1-k)
    assign kx   = XW'(r_k);
    assign nx   = XW'(n_act);
    assign hx   = (r_smooth > svh_pkg::SMOOTH_W'(1)) ? XW'(r_smooth[svh_pkg::SMOOTH_W-1:1]) : '0;
    assign room = nx - kx - XW'(1);
    assign w1   = (hx < kx) ? hx : kx;
    assign wx   = (w1 < room) ? w1 : room;

    // mean would exceed 32 bits
    assign sat_m = CMPW'({r_sum, svh_pkg::FRAC_W'(0)}) >= (CMPW'(r_cnt) << QB);

    // divider requests
    always_comb begin
        div_start = 1'b0;
        div_num   = DNW'(r_num);
        div_den   = {r_bin_size, 1'b0};
        div_steps = SBW'(AW);
        if (r_state == S_ACHK) begin
            div_start = !ovf_a;
        end else if (r_state == S_MCHK) begin
            div_start = !sat_m;
            div_num   = DNW'({r_sum, svh_pkg::FRAC_W'(0)});
            div_den   = DDW'(r_cnt);
            div_steps = SBW'(QB);
        end
    end

    // store ports: one write, one read, read data registered
    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_addr;
        mem_wd = '0;
        mem_ra = r_addr;
        if (r_state == S_CLR) begin
            mem_we = 1'b1;
        end else if (r_state == S_AINC) begin
            mem_we = 1'b1;
            mem_wa = r_bin;
            mem_wd = (r_rd_data == COUNT_MAX) ? r_rd_data : r_rd_data + 1'b1;
        end
        if (r_state == S_ADIV) begin
            mem_ra = q_bin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= mem[mem_ra];
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_size <= svh_pkg::BIN_SIZE_RST;
            r_start    <= svh_pkg::START_VALUE_RST;
            r_bins     <= svh_pkg::BINS_IN_USE_RST;
            r_smooth   <= svh_pkg::SMOOTH_WIDTH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                svh_pkg::CFG_BIN_SIZE:     r_bin_size <= i_cfg_data[svh_pkg::BIN_SIZE_W-1:0];
                svh_pkg::CFG_START_VALUE:  r_start    <= i_cfg_data[svh_pkg::START_W-1:0];
                svh_pkg::CFG_BINS_IN_USE:  r_bins     <= i_cfg_data[svh_pkg::BINS_W-1:0];
                svh_pkg::CFG_SMOOTH_WIDTH: r_smooth   <= i_cfg_data[svh_pkg::SMOOTH_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_addr   <= '0;
            r_valid  <= 1'b0;
            r_rd_vld <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_samp <= i_item.sample;
                        r_k    <= i_item.read_index;
                        unique case (i_item.operation)
                            svh_pkg::OP_ADD:   r_state <= S_ADIFF;
                            svh_pkg::OP_READ:  r_state <= S_RSET;
                            svh_pkg::OP_CLEAR: begin
                                r_addr  <= '0;
                                r_state <= S_CLR;
                            end
                            default: ;
                        endcase
                    end
                end
                S_CLR: begin
                    // zero sweep over the whole store
                    if (r_addr == AW'(NUM_BINS - 1)) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                end
                S_ADIFF: begin
                    r_neg <= diff[svh_pkg::SAMPLE_W];
                    r_mag <= diff[svh_pkg::SAMPLE_W] ? (~diff + 1'b1) : diff;
                    r_state <= drop_a ? S_IDLE : S_ANUM;
                end
                S_ANUM: begin
                    // round half away from zero: (2*mag + size) / (2*size)
                    r_num   <= {r_mag, 1'b0} + ANW'(r_bin_size);
                    r_state <= S_ACHK;
                end
                S_ACHK: begin
                    r_state <= ovf_a ? S_IDLE : S_ADIV;
                end
                S_ADIV: begin
                    if (div_done) begin
                        r_bin   <= q_bin;
                        r_state <= keep_a ? S_AINC : S_IDLE;
                    end
                end
                S_AINC: begin
                    r_state <= S_IDLE;
                end
                S_RSET: begin
                    if (kx >= nx) begin
                        // bin outside the active range reads as zero
                        r_valid                 <= 1'b1;
                        r_result.bin_index      <= r_k;
                        r_result.smoothed_value <= '0;
                        r_state                 <= S_IDLE;
                    end else begin
                        r_addr   <= AW'(kx - wx);
                        r_left   <= {wx[svh_pkg::SMOOTH_W-2:0], 1'b1};
                        r_cnt    <= {wx[svh_pkg::SMOOTH_W-2:0], 1'b1};
                        r_sum    <= '0;
                        r_rd_vld <= 1'b0;
                        r_state  <= S_SUM;
                    end
                end
                S_SUM: begin
                    // one read issued per cycle, its data summed in the following cycle
                    if (r_left != '0) begin
                        r_addr <= r_addr + 1'b1;
                        r_left <= r_left - 1'b1;
                    end
                    r_rd_vld <= (r_left != '0);
                    if (r_rd_vld) begin
                        r_sum <= r_sum + SUMW'(r_rd_data);
                    end
                    if ((r_left == '0) && !r_rd_vld) begin
                        r_state <= S_MCHK;
                    end
                end
                S_MCHK: begin
                    if (sat_m) begin
                        r_valid                 <= 1'b1;
                        r_result.bin_index      <= r_k;
                        r_result.smoothed_value <= '1;
                        r_state                 <= S_IDLE;
                    end else begin
                        r_state <= S_MDIV;
                    end
                end
                S_MDIV: begin
                    if (div_done) begin
                        r_valid                 <= 1'b1;
                        r_result.bin_index      <= r_k;
                        r_result.smoothed_value <= div_quo[svh_pkg::VALUE_W-1:0];
                        r_state                 <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    svh_div #(
        .NW (DNW),
        .DW (DDW),
        .QB (QB)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .i_steps (div_steps),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign o_valid  = r_valid;
    assign o_result = r_result;

    // a result lasts one cycle
    a_single_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held longer than one cycle");

    // results only come out of the read path
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(r_state) == S_RSET || $past(r_state) == S_MCHK
                     || $past(r_state) == S_MDIV))
        else $error("result raised outside a read");

    // increments only hit active bins
    a_inc_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_AINC) |-> (NBW'(r_bin) < n_act))
        else $error("increment of an inactive bin");

    // the divider finishes only while it is waited on
    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_ADIV || r_state == S_MDIV))
        else $error("divider done while not waited on");

    // no item is taken during the clearing sweep
    a_clr_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR) |-> busy)
        else $error("idle during clear sweep");

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 100ps
// self-checking testbench of the smoothed value histogram: directed and random items
module tb_top;
    import svh_pkg::*;

    // the one operation code that the block must ignore
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int NBINS = NUM_BINS_DEF;
    localparam int CW    = COUNT_WIDTH_DEF;

    // longest silent work: a clear sweeps every bin, a wide read walks 2w+1 bins
    localparam int SETTLE_CYCLES = 2 * NBINS + 80;
    // give up on a missing result after this many cycles
    localparam int DRAIN_GUARD   = 20000;
    localparam int RANDOM_ITEMS  = 1200;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  start      = 1'b0;
    t_in_item              i_item     = '0;
    logic                  busy;
    logic                  o_valid;
    t_out_item             o_result;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    smoothed_value_histogram_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_item     (i_item),
        .busy       (busy),
        .o_valid    (o_valid),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // 4 ns period
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // histogram model: its own count store and copy of the registers
    // ------------------------------------------------------------------
    bit [CW-1:0]         hist_counts [NBINS];
    bit [BIN_SIZE_W-1:0] cfg_bin_size = BIN_SIZE_RST;
    bit [START_W-1:0]    cfg_start    = START_VALUE_RST;
    bit [BINS_W-1:0]     cfg_bins     = BINS_IN_USE_RST;
    bit [SMOOTH_W-1:0]   cfg_smooth   = SMOOTH_WIDTH_RST;

    // read results still owed by the block, oldest first
    t_out_item expected_means [$];
    // items waiting to be offered to the block
    t_in_item  item_backlog [$];

    int err_count      = 0;
    int results_seen   = 0;
    int items_queued   = 0;
    int items_taken    = 0;
    int adds_taken     = 0;
    int reads_taken    = 0;
    int clears_taken   = 0;
    int ignored_taken  = 0;
    int stim_count     = 0;
    int settings_count = 0;
    int gap_left       = 0;
    int burst_left     = 0;

    // bins in use, clamped to the size of the store
    function automatic int unsigned bins_active();
        return (cfg_bins > NBINS) ? NBINS : int'(cfg_bins);
    endfunction

    // round to nearest bin, ties away from zero, then count with saturation
    function automatic void tally_sample(logic signed [SAMPLE_W-1:0] s);
        longint            d;
        longint unsigned   mag, q, n;
        n = bins_active();
        if (s == 0 || cfg_bin_size == 0 || n == 0) return;
        d   = longint'(s) - longint'($signed(cfg_start));
        mag = (d < 0) ? longint'(-d) : d;
        q   = (2 * mag + longint'(cfg_bin_size)) / (2 * longint'(cfg_bin_size));
        if (d < 0 && q != 0) return;
        if (q >= n) return;
        if (hist_counts[q] != {CW{1'b1}}) hist_counts[q]++;
    endfunction

    // mean over the centered window, narrowed near either end of the used bins
    function automatic logic [VALUE_W-1:0] window_mean(int unsigned k);
        int unsigned     n, h, w;
        longint unsigned total, v;
        n = bins_active();
        if (k >= n) return '0;
        h = (cfg_smooth > 1) ? cfg_smooth / 2 : 0;
        w = h;
        if (k < w) w = k;
        if (n - 1 - k < w) w = n - 1 - k;
        total = 0;
        for (int unsigned i = k - w; i <= k + w; i++) total += hist_counts[i];
        v = (total << 8) / (2 * w + 1);
        return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    function automatic void predict_item(t_in_item it);
        t_out_item r;
        case (it.operation)
            OP_ADD: begin
                tally_sample(it.sample);
                adds_taken++;
            end
            OP_READ: begin
                r.bin_index      = it.read_index;
                r.smoothed_value = window_mean(it.read_index);
                expected_means.push_back(r);
                reads_taken++;
            end
            OP_CLEAR: begin
                foreach (hist_counts[i]) hist_counts[i] = '0;
                clears_taken++;
            end
            default: ignored_taken++;
        endcase
    endfunction

    function automatic void note_error(string msg);
        err_count++;
        if (err_count <= 10) $display("mismatch at %0t: %s", $realtime, msg);
    endfunction

    // idle cycles after an item: mostly none or short, a few long, some bursts
    function automatic int pick_gap();
        int unsigned roll;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
            burst_left = $urandom_range(20, 120);
            return 0;
        end
        if (roll < 50) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 16);
        return $urandom_range(20, 120);
    endfunction

    // ------------------------------------------------------------------
    // driver: offers backlog items, holds each until start & !busy
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                predict_item(i_item);
                items_taken++;
            end
            // an item offered but not yet taken stays on the port
            if (!(start && busy)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    start <= 1'b0;
                end else if (item_backlog.size() > 0) begin
                    i_item   <= item_backlog.pop_front();
                    start    <= 1'b1;
                    gap_left = pick_gap();
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: every strobed result against the oldest expected mean
    // ------------------------------------------------------------------
    t_out_item want_mean;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1) begin
            if (expected_means.size() == 0) begin
                note_error($sformatf("unexpected result bin %0d value 0x%08h",
                                     o_result.bin_index, o_result.smoothed_value));
            end else begin
                want_mean = expected_means.pop_front();
                results_seen++;
                if (o_result.bin_index !== want_mean.bin_index)
                    note_error($sformatf("bin_index exp %0d got %0d",
                                         want_mean.bin_index, o_result.bin_index));
                if (o_result.smoothed_value !== want_mean.smoothed_value)
                    note_error($sformatf("bin %0d smoothed_value exp 0x%08h got 0x%08h",
                                         want_mean.bin_index, want_mean.smoothed_value,
                                         o_result.smoothed_value));
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic void queue_item(logic [OP_W-1:0] op, logic [SAMPLE_W-1:0] s,
                                       logic [INDEX_W-1:0] idx);
        t_in_item it;
        it.operation  = op;
        it.sample     = s;
        it.read_index = idx;
        item_backlog.push_back(it);
        items_queued++;
    endfunction

    // register write; the model takes the value at once since the block is idle
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_BIN_SIZE:     cfg_bin_size = data[BIN_SIZE_W-1:0];
            CFG_START_VALUE:  cfg_start    = data[START_W-1:0];
            CFG_BINS_IN_USE:  cfg_bins     = data[BINS_W-1:0];
            CFG_SMOOTH_WIDTH: cfg_smooth   = data[SMOOTH_W-1:0];
            default: ;
        endcase
    endtask

    // all four registers; unused upper data bits carry noise
    task automatic set_regs(logic [BIN_SIZE_W-1:0] bs, logic [START_W-1:0] sv,
                            logic [BINS_W-1:0] nb, logic [SMOOTH_W-1:0] sw);
        logic [31:0] noise;
        noise = $urandom();
        write_reg(CFG_BIN_SIZE, {noise[31], bs});
        write_reg(CFG_START_VALUE, sv);
        write_reg(CFG_BINS_IN_USE, {noise[22:0], nb});
        write_reg(CFG_SMOOTH_WIDTH, {noise[23:0], sw});
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        settings_count++;
    endtask

    // wait until every item is taken and every read answered, then let silent work end
    task automatic wait_drained();
        int guard;
        guard = 0;
        while ((items_taken != items_queued || expected_means.size() != 0)
               && guard < DRAIN_GUARD) begin
            @(posedge i_clk);
            guard++;
        end
        if (expected_means.size() != 0) begin
            note_error($sformatf("%0d read results never arrived", expected_means.size()));
            expected_means.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        guard = 0;
        while (busy !== 1'b0 && guard < DRAIN_GUARD) begin
            @(posedge i_clk);
            guard++;
        end
    endtask

    // mostly samples aimed near bin centers and exact ties, some raw noise; also reads, clears and unused codes
    function automatic t_in_item make_item();
        t_in_item    it;
        int unsigned roll, n;
        longint      q, jit, half;
        it.operation  = OP_ADD;
        it.sample     = $urandom();
        it.read_index = $urandom();
        n    = bins_active();
        roll = $urandom_range(0, 99);
        if (roll < 62) begin
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
                it.sample = '0;
            end else if (roll < 78) begin
                half = cfg_bin_size / 2;
                q    = $urandom_range(0, n + 2);
                if ($urandom_range(0, 7) == 0)
                    jit = $urandom_range(0, 1) ? half : -half;
                else
                    jit = longint'($urandom_range(0, 32'(2 * half))) - half;
                it.sample = 32'(longint'($signed(cfg_start)) + q * cfg_bin_size + jit);
            end
        end else if (roll < 92) begin
            it.operation = OP_READ;
            if (n > 0 && $urandom_range(0, 99) < 85)
                it.read_index = $urandom_range(0, n - 1);
        end else if (roll < 95) begin
            it.operation = OP_CLEAR;
        end else begin
            it.operation = OP_UNUSED;
        end
        return it;
    endfunction

    // n items that the block actually works on, ignored ones come on top
    task automatic random_items(int n);
        t_in_item it;
        int       done;
        done = 0;
        while (done < n) begin
            it = make_item();
            queue_item(it.operation, it.sample, it.read_index);
            if (!(it.operation == OP_UNUSED || (it.operation == OP_ADD && it.sample == 0))) begin
                done++;
                stim_count++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    logic [BIN_SIZE_W-1:0] r_bs;
    logic [START_W-1:0]    r_sv;
    logic [BINS_W-1:0]     r_nb;
    logic [SMOOTH_W-1:0]   r_sw;

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // reset also clears the store; wait for that sweep
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);

        // directed: unit bins from zero, all 256 in use, no smoothing
        set_regs(BIN_SIZE_RST, START_VALUE_RST, BINS_IN_USE_RST, SMOOTH_WIDTH_RST);
        queue_item(OP_ADD, 32'h0000_0000, 8'h00);   // zero sample is skipped
        queue_item(OP_ADD, 32'h7FFF_FFFF, 8'h00);   // far above the last bin
        queue_item(OP_ADD, 32'h8000_0000, 8'h00);   // most negative value
        queue_item(OP_ADD, 32'h0000_0001, 8'h00);   // rounds down into bin 0
        queue_item(OP_ADD, 32'h0000_8000, 8'h00);   // half bin up rounds to bin 1
        queue_item(OP_ADD, 32'hFFFF_8000, 8'h00);   // half bin down rounds to -1, dropped
        queue_item(OP_ADD, 32'hFFFF_8001, 8'h00);   // just under half below, bin 0
        queue_item(OP_ADD, 32'h00FF_0000, 8'h00);   // last bin
        queue_item(OP_ADD, 32'h0100_0000, 8'h00);   // one past the last bin
        queue_item(OP_ADD, 32'h0003_0000, 8'h00);
        queue_item(OP_ADD, 32'h0003_0000, 8'h00);
        queue_item(OP_UNUSED, 32'hFFFF_FFFF, 8'hFF);
        queue_item(OP_READ, 32'h0000_0000, 8'h00);
        queue_item(OP_READ, 32'hFFFF_FFFF, 8'h01);
        queue_item(OP_READ, 32'h0000_0000, 8'h03);
        queue_item(OP_READ, 32'h0000_0000, 8'hFF);
        queue_item(OP_READ, 32'h0000_0000, 8'h80);
        queue_item(OP_CLEAR, 32'h0000_0000, 8'h00);
        queue_item(OP_READ, 32'h0000_0000, 8'h03);
        queue_item(OP_READ, 32'h0000_0000, 8'h00);
        wait_drained();

        // extreme settings: tiny bins from the bottom of the range, widest window
        set_regs(31'd1, 32'h8000_0000, 9'd1, 8'd255);
        random_items(60);
        wait_drained();
        // largest bins from the top, bins in use beyond the store, width one
        set_regs(31'h7FFF_FFFF, 32'h7FFF_FFFF, 9'd511, 8'd1);
        random_items(60);
        wait_drained();
        // zero bin size and zero bins: nothing counted, every read is zero
        set_regs(31'd0, $urandom(), 9'd0, 8'd2);
        random_items(40);
        wait_drained();
        // full store with the widest window around a negative start
        set_regs(31'h0001_0000, 32'hFF80_0000, 9'd256, 8'd255);
        random_items(100);
        wait_drained();
        // half-unit bins, one past the store
        set_regs(31'h0000_8000, 32'h0000_0000, 9'd257, 8'd3);
        random_items(60);
        wait_drained();

        // random settings until enough items have gone through
        while (stim_count < RANDOM_ITEMS) begin
            case ($urandom_range(0, 3))
                0:       r_bs = $urandom_range(1, 64);
                1:       r_bs = 31'($urandom_range(1, 64)) << 16;
                2:       r_bs = $urandom_range(1, 1 << 20);
                default: r_bs = $urandom();
            endcase
            r_sv = ($urandom_range(0, 1) != 0) ? $urandom() : 32'($signed($urandom_range(0, 2000)) - 1000) <<< 12;
            case ($urandom_range(0, 9))
                0:       r_nb = 9'd0;
                1:       r_nb = $urandom_range(257, 511);
                default: r_nb = $urandom_range(1, 256);
            endcase
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: r_sw = $urandom_range(0, 8);
                5, 6, 7:       r_sw = $urandom_range(0, 40);
                default:       r_sw = $urandom();
            endcase
            set_regs(r_bs, r_sv, r_nb, r_sw);
            random_items(100);
            wait_drained();
        end

        $display("summary: %0d items taken (%0d adds, %0d reads, %0d clears, %0d ignored)",
                 items_taken, adds_taken, reads_taken, clears_taken, ignored_taken);
        $display("summary: %0d register settings, %0d results checked, %0d mismatches",
                 settings_count, results_seen, err_count);
        if (err_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

    // run limit: several times the slowest legal run
    initial begin
        #10_000_000;
        $display("timeout with %0d of %0d items taken", items_taken, items_queued);
        $display("tb_top: errors");
        $finish;
    end

endmodule
